// ----- hw/rtl/vchp_pkg.sv -----
package vchp_pkg;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_OK    = 2'd2;
   localparam logic [1:0] KIND_FAIL  = 2'd3;

   localparam logic [2:0] CAUSE_NONE    = 3'd0;
   localparam logic [2:0] CAUSE_SHORT   = 3'd1;
   localparam logic [2:0] CAUSE_VENDOR  = 3'd2;
   localparam logic [2:0] CAUSE_COUNT   = 3'd3;
   localparam logic [2:0] CAUSE_COMMENT = 3'd4;

   localparam logic [31:0] MIN_BLOCK_BYTES = 32'd8;

   // One queue entry: the first result of a request, and whether a success
   // result follows it in the same request.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] comment_byte;
      logic       end_of_comment;
      logic [2:0] fail_cause;
      logic       ok_after;
   } rsp_entry_type;

endpackage

// ----- hw/rtl/vchp_front.sv -----
module vchp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   start_req,
   input  logic [7:0]             data_byte,
   input  logic [31:0]            buffer_length,
   output logic                   res_valid,
   output vchp_pkg::rsp_entry_type res_entry
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_VLEN  = 3'd1;
   localparam logic [2:0] PH_VSKIP = 3'd2;
   localparam logic [2:0] PH_COUNT = 3'd3;
   localparam logic [2:0] PH_CLEN  = 3'd4;
   localparam logic [2:0] PH_BODY  = 3'd5;
   localparam logic [2:0] PH_DONE  = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] expected_ff, expected_in;
   logic [31:0] limit_ff, limit_in;
   logic [31:0] comments_ff, comments_in;
   logic [31:0] field_ff, field_in;

   logic [2:0]  eff_phase;
   logic [1:0]  eff_idx;
   logic [31:0] eff_shift;
   logic [31:0] eff_expected;
   logic [31:0] eff_limit;
   logic        short_block;
   logic [31:0] word_next;
   logic        word_done;
   logic [33:0] amount;
   logic [34:0] sum;
   logic        over;

   // A start request restarts the parse and the same byte is then parsed.
   always_comb begin
      eff_phase    = phase_ff;
      eff_idx      = idx_ff;
      eff_shift    = shift_ff;
      eff_expected = expected_ff;
      eff_limit    = limit_ff;
      short_block  = 1'b0;
      if (start_req) begin
         eff_phase    = PH_VLEN;
         eff_idx      = 2'd0;
         eff_shift    = 32'd0;
         eff_expected = vchp_pkg::MIN_BLOCK_BYTES;
         eff_limit    = buffer_length;
         short_block  = (buffer_length < vchp_pkg::MIN_BLOCK_BYTES);
      end
   end

   assign word_next = {data_byte, eff_shift[31:8]};
   assign word_done = (eff_idx == 2'd3);
   assign amount    = (eff_phase == PH_COUNT) ? {word_next, 2'b00} : {2'b00, word_next};

   // The expected length never exceeds the 32-bit limit while parsing goes
   // on, so it is kept in 32 bits and the sum cannot overflow 35 bits.
   assign sum  = {3'b000, eff_expected} + {1'b0, amount};
   assign over = (sum > {3'b000, eff_limit});

   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      shift_in    = shift_ff;
      expected_in = expected_ff;
      limit_in    = limit_ff;
      comments_in = comments_ff;
      field_in    = field_ff;
      res_valid   = 1'b0;
      res_entry   = '0;
      if (accept) begin
         phase_in    = eff_phase;
         idx_in      = eff_idx;
         shift_in    = eff_shift;
         expected_in = eff_expected;
         limit_in    = eff_limit;
         if (start_req) begin
            comments_in = 32'd0;
            field_in    = 32'd0;
         end
         if (short_block) begin
            res_valid            = 1'b1;
            res_entry.kind       = vchp_pkg::KIND_FAIL;
            res_entry.fail_cause = vchp_pkg::CAUSE_SHORT;
            phase_in             = PH_DONE;
         end else begin
            unique case (eff_phase)
               PH_VLEN, PH_COUNT, PH_CLEN: begin
                  shift_in = word_next;
                  if (!word_done) begin
                     idx_in = eff_idx + 2'd1;
                  end else begin
                     idx_in      = 2'd0;
                     expected_in = sum[31:0];
                     if (over) begin
                        res_valid      = 1'b1;
                        res_entry.kind = vchp_pkg::KIND_FAIL;
                        phase_in       = PH_DONE;
                        priority if (eff_phase == PH_VLEN) begin
                           res_entry.fail_cause = vchp_pkg::CAUSE_VENDOR;
                        end else if (eff_phase == PH_COUNT) begin
                           res_entry.fail_cause = vchp_pkg::CAUSE_COUNT;
                        end else begin
                           res_entry.fail_cause = vchp_pkg::CAUSE_COMMENT;
                        end
                     end else if (eff_phase == PH_VLEN) begin
                        field_in = word_next;
                        phase_in = (word_next == 32'd0) ? PH_COUNT : PH_VSKIP;
                     end else if (eff_phase == PH_COUNT) begin
                        comments_in = word_next;
                        if (word_next == 32'd0) begin
                           res_valid      = 1'b1;
                           res_entry.kind = vchp_pkg::KIND_OK;
                           phase_in       = PH_DONE;
                        end else begin
                           phase_in = PH_CLEN;
                        end
                     end else if (word_next == 32'd0) begin
                        res_valid                = 1'b1;
                        res_entry.kind           = vchp_pkg::KIND_EMPTY;
                        res_entry.end_of_comment = 1'b1;
                        res_entry.ok_after       = (comments_ff == 32'd1);
                        comments_in              = comments_ff - 32'd1;
                        phase_in = (comments_ff == 32'd1) ? PH_DONE : PH_CLEN;
                     end else begin
                        field_in = word_next;
                        phase_in = PH_BODY;
                     end
                  end
               end
               PH_VSKIP: begin
                  field_in = field_ff - 32'd1;
                  if (field_ff == 32'd1) begin
                     phase_in = PH_COUNT;
                  end
               end
               PH_BODY: begin
                  field_in                 = field_ff - 32'd1;
                  res_valid                = 1'b1;
                  res_entry.kind           = vchp_pkg::KIND_BYTE;
                  res_entry.comment_byte   = data_byte;
                  res_entry.end_of_comment = (field_ff == 32'd1);
                  if (field_ff == 32'd1) begin
                     comments_in        = comments_ff - 32'd1;
                     res_entry.ok_after = (comments_ff == 32'd1);
                     phase_in = (comments_ff == 32'd1) ? PH_DONE : PH_CLEN;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         idx_ff      <= 2'd0;
         shift_ff    <= 32'd0;
         expected_ff <= 32'd0;
         limit_ff    <= 32'd0;
         comments_ff <= 32'd0;
         field_ff    <= 32'd0;
      end else begin
         phase_ff    <= phase_in;
         idx_ff      <= idx_in;
         shift_ff    <= shift_in;
         expected_ff <= expected_in;
         limit_ff    <= limit_in;
         comments_ff <= comments_in;
         field_ff    <= field_in;
      end
   end

endmodule

// ----- hw/rtl/vchp_queue.sv -----
module vchp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  vchp_pkg::rsp_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output vchp_pkg::rsp_entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   vchp_pkg::rsp_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- hw/rtl/vchp_back.sv -----
module vchp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  vchp_pkg::rsp_entry_type q_head,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_comment_byte,
   output logic                   rsp_end_of_comment,
   output logic [2:0]             rsp_fail_cause
);

   // Set while the success result that trails the head entry is on show.
   logic second_ff, second_in;
   logic taken;

   assign rsp_empty = q_empty;
   assign taken     = rsp_pop && !q_empty;

   always_comb begin
      if (second_ff) begin
         rsp_kind           = vchp_pkg::KIND_OK;
         rsp_comment_byte   = 8'd0;
         rsp_end_of_comment = 1'b0;
         rsp_fail_cause     = vchp_pkg::CAUSE_NONE;
      end else begin
         rsp_kind           = q_head.kind;
         rsp_comment_byte   = q_head.comment_byte;
         rsp_end_of_comment = q_head.end_of_comment;
         rsp_fail_cause     = q_head.fail_cause;
      end
   end

   always_comb begin
      second_in = second_ff;
      q_pop     = 1'b0;
      if (taken) begin
         if (!second_ff && q_head.ok_after) begin
            second_in = 1'b1;
         end else begin
            second_in = 1'b0;
            q_pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

// ----- hw/rtl/vorbis_comment_header_parser.sv -----
// Channel   Handshake        Payload
// request   req_push/full    req_start_req, req_data_byte, req_buffer_length
// response  rsp_pop/empty    rsp_kind, rsp_comment_byte, rsp_end_of_comment,
//                            rsp_fail_cause
//
// One request byte is parsed per cycle while req_full is low; its results are
// written to a queue of QUEUE_DEPTH entries in the same cycle. A request
// yields up to two results, and one that yields two occupies the response
// side for two pops. Reset is synchronous and clears the parser, the queue
// and the response stage. req_full is high only while the queue is full, so
// requests stall only when responses have not been popped.
module vorbis_comment_header_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_start_req,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_buffer_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_comment_byte,
   output logic        rsp_end_of_comment,
   output logic [2:0]  rsp_fail_cause
);

   logic                    accept;
   logic                    res_valid;
   vchp_pkg::rsp_entry_type res_entry;
   logic                    q_empty;
   logic                    q_pop;
   vchp_pkg::rsp_entry_type q_head;

   assign accept = req_push && !req_full;

   vchp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .start_req     (req_start_req),
      .data_byte     (req_data_byte),
      .buffer_length (req_buffer_length),
      .res_valid     (res_valid),
      .res_entry     (res_entry)
   );

   vchp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_entry (res_entry),
      .full       (req_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   vchp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kind           (rsp_kind),
      .rsp_comment_byte   (rsp_comment_byte),
      .rsp_end_of_comment (rsp_end_of_comment),
      .rsp_fail_cause     (rsp_fail_cause)
   );

endmodule

// ----- test/vorbis_comment_header_parser_tb.sv -----
module vorbis_comment_header_parser_tb;

   localparam int          RANDOM_ITEMS = 1100;
   localparam int          HOLD_AT      = 150;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          STALL_LIMIT  = 3000;
   localparam int          TAIL_CYCLES  = 20;
   localparam logic [39:0] NEED_MAX     = 40'hFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      PS_IDLE,
      PS_VENDOR_LEN,
      PS_VENDOR_SKIP,
      PS_COUNT,
      PS_COMMENT_LEN,
      PS_COMMENT_BODY,
      PS_DONE
   } parse_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] comment_byte;
      logic       end_of_comment;
      logic [2:0] fail_cause;
   } parse_event_type;

   typedef struct packed {
      logic       start;
      logic [7:0] data;
      logic [31:0] blen;
      logic       typed;
      logic [1:0] kind;
      logic [2:0] cause;
   } dir_row_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_push           = 1'b0;
   logic        req_full;
   logic        req_start_req      = 1'b0;
   logic [7:0]  req_data_byte      = 8'h00;
   logic [31:0] req_buffer_length  = 32'h0;
   logic        rsp_empty;
   logic        rsp_pop            = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_comment_byte;
   logic        rsp_end_of_comment;
   logic [2:0]  rsp_fail_cause;

   // Typed-in expectation travelling with the request it belongs to.
   logic        row_typed = 1'b0;
   logic [1:0]  row_kind  = vchp_pkg::KIND_BYTE;
   logic [2:0]  row_cause = vchp_pkg::CAUSE_NONE;

   parse_event_type parse_events[$];
   logic [7:0]      block_bytes[$];
   int              error_count  = 0;
   int              stall_cycles = 0;
   bit              tx_burst     = 1'b0;
   bit              rx_burst     = 1'b0;

   parse_state_type ps_state    = PS_IDLE;
   logic [1:0]      ps_byte_idx = 2'd0;
   logic [31:0]     ps_word     = 32'h0;
   logic [39:0]     ps_need     = 40'h0;
   logic [31:0]     ps_limit    = 32'h0;
   logic [31:0]     ps_comments = 32'h0;
   logic [31:0]     ps_field    = 32'h0;

   dir_row_type directed_rows [29] = '{
      '{1'b1, 8'h00, 32'h0000_0000, 1'b1, vchp_pkg::KIND_FAIL, vchp_pkg::CAUSE_SHORT},
      '{1'b1, 8'hFF, 32'h0000_0007, 1'b1, vchp_pkg::KIND_FAIL, vchp_pkg::CAUSE_SHORT},
      '{1'b0, 8'h5A, 32'hFFFF_FFFF, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'hFF, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'hFF, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'hFF, 32'h0000_0000, 1'b1, vchp_pkg::KIND_FAIL, vchp_pkg::CAUSE_VENDOR},
      '{1'b1, 8'h00, 32'd8,         1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b1, vchp_pkg::KIND_OK,   vchp_pkg::CAUSE_NONE},
      '{1'b1, 8'h00, 32'd12,        1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b1, 8'h00, 32'd12,        1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h01, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE},
      '{1'b0, 8'h00, 32'h0000_0000, 1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE}
   };

   vorbis_comment_header_parser u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_start_req      (req_start_req),
      .req_data_byte      (req_data_byte),
      .req_buffer_length  (req_buffer_length),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kind           (rsp_kind),
      .rsp_comment_byte   (rsp_comment_byte),
      .rsp_end_of_comment (rsp_end_of_comment),
      .rsp_fail_cause     (rsp_fail_cause)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic parse_event_type mk_event(logic [1:0] kind, logic [7:0] cbyte,
                                                logic eoc, logic [2:0] cause);
      parse_event_type ev;
      ev.kind           = kind;
      ev.comment_byte   = cbyte;
      ev.end_of_comment = eoc;
      ev.fail_cause     = cause;
      return ev;
   endfunction

   function automatic logic [39:0] grow_need(logic [39:0] acc, logic [39:0] amount);
      logic [39:0] room;
      room = NEED_MAX - acc;
      return (amount >= room) ? NEED_MAX : acc + amount;
   endfunction

   // Closes one comment; the last one also ends the parse with success.
   function automatic bit close_comment(output parse_event_type ev);
      ps_comments = ps_comments - 32'd1;
      ev = mk_event(vchp_pkg::KIND_OK, 8'h00, 1'b0, vchp_pkg::CAUSE_NONE);
      if (ps_comments == 32'd0) begin
         ps_state = PS_DONE;
         return 1'b1;
      end
      ps_state = PS_COMMENT_LEN;
      return 1'b0;
   endfunction

   function automatic int parse_byte(input logic start, input logic [7:0] b,
                                     input logic [31:0] blen,
                                     output parse_event_type ev0,
                                     output parse_event_type ev1);
      logic [31:0] value;
      ev0 = '0;
      ev1 = '0;
      if (start) begin
         ps_limit    = blen;
         ps_need     = 40'd8;
         ps_byte_idx = 2'd0;
         ps_word     = 32'h0;
         ps_comments = 32'h0;
         ps_field    = 32'h0;
         if (blen < vchp_pkg::MIN_BLOCK_BYTES) begin
            ev0      = mk_event(vchp_pkg::KIND_FAIL, 8'h00, 1'b0, vchp_pkg::CAUSE_SHORT);
            ps_state = PS_DONE;
            return 1;
         end
         ps_state = PS_VENDOR_LEN;
      end
      case (ps_state)
         PS_VENDOR_LEN, PS_COUNT, PS_COMMENT_LEN: begin
            ps_word = {b, ps_word[31:8]};
            if (ps_byte_idx != 2'd3) begin
               ps_byte_idx = ps_byte_idx + 2'd1;
               return 0;
            end
            ps_byte_idx = 2'd0;
            value       = ps_word;
            if (ps_state == PS_VENDOR_LEN) begin
               ps_need = grow_need(ps_need, {8'd0, value});
               if ({8'd0, ps_limit} < ps_need) begin
                  ev0 = mk_event(vchp_pkg::KIND_FAIL, 8'h00, 1'b0,
                                 vchp_pkg::CAUSE_VENDOR);
                  ps_state = PS_DONE;
                  return 1;
               end
               ps_field = value;
               ps_state = (value == 32'd0) ? PS_COUNT : PS_VENDOR_SKIP;
               return 0;
            end
            if (ps_state == PS_COUNT) begin
               ps_need = grow_need(ps_need, {6'd0, value, 2'b00});
               if ({8'd0, ps_limit} < ps_need) begin
                  ev0 = mk_event(vchp_pkg::KIND_FAIL, 8'h00, 1'b0,
                                 vchp_pkg::CAUSE_COUNT);
                  ps_state = PS_DONE;
                  return 1;
               end
               ps_comments = value;
               if (value == 32'd0) begin
                  ev0      = mk_event(vchp_pkg::KIND_OK, 8'h00, 1'b0, vchp_pkg::CAUSE_NONE);
                  ps_state = PS_DONE;
                  return 1;
               end
               ps_state = PS_COMMENT_LEN;
               return 0;
            end
            ps_need = grow_need(ps_need, {8'd0, value});
            if ({8'd0, ps_limit} < ps_need) begin
               ev0      = mk_event(vchp_pkg::KIND_FAIL, 8'h00, 1'b0, vchp_pkg::CAUSE_COMMENT);
               ps_state = PS_DONE;
               return 1;
            end
            if (value == 32'd0) begin
               ev0 = mk_event(vchp_pkg::KIND_EMPTY, 8'h00, 1'b1, vchp_pkg::CAUSE_NONE);
               return close_comment(ev1) ? 2 : 1;
            end
            ps_field = value;
            ps_state = PS_COMMENT_BODY;
            return 0;
         end
         PS_VENDOR_SKIP: begin
            if (ps_field != 32'd0) ps_field = ps_field - 32'd1;
            if (ps_field == 32'd0) ps_state = PS_COUNT;
            return 0;
         end
         PS_COMMENT_BODY: begin
            if (ps_field != 32'd0) ps_field = ps_field - 32'd1;
            ev0 = mk_event(vchp_pkg::KIND_BYTE, b, ps_field == 32'd0, vchp_pkg::CAUSE_NONE);
            if (ps_field != 32'd0) return 1;
            return close_comment(ev1) ? 2 : 1;
         end
         default: return 0;
      endcase
   endfunction

   always @(posedge clock) begin : track
      parse_event_type e0, e1, want;
      int n;
      if (reset) begin
         ps_state    = PS_IDLE;
         ps_byte_idx = 2'd0;
         ps_word     = 32'h0;
         ps_need     = 40'h0;
         ps_limit    = 32'h0;
         ps_comments = 32'h0;
         ps_field    = 32'h0;
         parse_events.delete();
      end else begin
         if (req_push && !req_full) begin
            n = parse_byte(req_start_req, req_data_byte, req_buffer_length, e0, e1);
            if (row_typed) begin
               parse_events.push_back(mk_event(row_kind, 8'h00, 1'b0, row_cause));
            end else begin
               if (n > 0) parse_events.push_back(e0);
               if (n > 1) parse_events.push_back(e1);
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (parse_events.size() == 0) begin
               $display({"%0t: unexpected result: expected none, ",
                         "actual kind %0d byte %02h eoc %0d cause %0d"},
                        $time, rsp_kind, rsp_comment_byte, rsp_end_of_comment,
                        rsp_fail_cause);
               error_count++;
            end else begin
               want = parse_events.pop_front();
               if (rsp_kind !== want.kind || rsp_comment_byte !== want.comment_byte ||
                   rsp_end_of_comment !== want.end_of_comment ||
                   rsp_fail_cause !== want.fail_cause) begin
                  $display({"%0t: mismatch: expected kind %0d byte %02h eoc %0d cause %0d, ",
                            "actual kind %0d byte %02h eoc %0d cause %0d"},
                           $time, want.kind, want.comment_byte, want.end_of_comment,
                           want.fail_cause, rsp_kind, rsp_comment_byte,
                           rsp_end_of_comment, rsp_fail_cause);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("vorbis_comment_header_parser_tb: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic push_request(input logic start, input logic [7:0] data,
                               input logic [31:0] blen, input logic typed,
                               input logic [1:0] kind, input logic [2:0] cause);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push          <= 1'b1;
      req_start_req     <= start;
      req_data_byte     <= data;
      req_buffer_length <= blen;
      row_typed         <= typed;
      row_kind          <= kind;
      row_cause         <= cause;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic append_word(input logic [31:0] w);
      block_bytes.push_back(w[7:0]);
      block_bytes.push_back(w[15:8]);
      block_bytes.push_back(w[23:16]);
      block_bytes.push_back(w[31:24]);
   endtask

   // One block: mostly well formed with random content, the rest short, corrupt or cut off.
   task automatic send_block(inout int sent);
      int          vlen, ncom, clen, pick, total, nsend, k, base;
      logic [31:0] blen, w;
      block_bytes.delete();
      vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      append_word(32'(vlen));
      repeat (vlen) block_bytes.push_back(8'($urandom));
      ncom = $urandom_range(0, 4);
      append_word(32'(ncom));
      repeat (ncom) begin
         clen = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
         append_word(32'(clen));
         repeat (clen) block_bytes.push_back(8'($urandom));
      end
      total = block_bytes.size();
      blen  = 32'(total);
      pick  = $urandom_range(0, 99);
      if (pick >= 55 && pick < 68) begin
         blen = 32'(total + $urandom_range(1, 50));
      end else if (pick >= 68 && pick < 80) begin
         blen = 32'($urandom_range(0, total - 1));
      end else if (pick >= 80 && pick < 86) begin
         blen = $urandom;
      end else if (pick >= 86) begin
         // Overwrite the comment count, or the vendor length, with a random word.
         base = (pick < 93) ? 4 + vlen : 0;
         w    = $urandom;
         for (k = 0; k < 4; k++) block_bytes[base + k] = w[8*k +: 8];
      end
      nsend    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total;
      tx_burst = ($urandom_range(0, 3) == 0);
      for (k = 0; k < nsend; k++) begin
         push_request(k == 0, block_bytes[k], (k == 0) ? blen : $urandom,
                      1'b0, vchp_pkg::KIND_BYTE, vchp_pkg::CAUSE_NONE);
      end
      sent += nsend;
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            push_request(1'b0, 8'($urandom), $urandom, 1'b0, vchp_pkg::KIND_BYTE,
                         vchp_pkg::CAUSE_NONE);
         end
      end
   endtask

   task automatic drain_requests();
      req_push <= 1'b0;
      do @(negedge clock); while (parse_events.size() != 0);
   endtask

   initial begin : sender
      int  sent;
      bit  paused;
      sent   = 0;
      paused = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         push_request(directed_rows[i].start, directed_rows[i].data, directed_rows[i].blen,
                      directed_rows[i].typed, directed_rows[i].kind, directed_rows[i].cause);
      end
      drain_requests();
      while (sent < RANDOM_ITEMS) begin
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            drain_requests();
         end
         send_block(sent);
      end
      drain_requests();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("vorbis_comment_header_parser_tb: PASS");
      end else begin
         $display("vorbis_comment_header_parser_tb: FAIL");
      end
      $finish;
   end

   // Result side; once it holds off long enough for the queue to fill and stall requests.
   initial begin : receiver
      int popped, gap;
      popped = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = rx_burst ? 0 : $urandom_range(0, 4);
         if (popped == HOLD_AT) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         popped++;
         if (popped % 64 == 0) rx_burst = ($urandom_range(0, 2) == 0);
         @(negedge clock);
      end
   end

endmodule
